// ===== rtl/core/fwrmms_pkg.sv =====
// Shared types and constants for the FIFO with running min/max/sum.
package fwrmms_pkg;

    // Fixed port widths.
    localparam int DATA_W   = 32;
    localparam int SUM_W    = 36;
    localparam int TOTAL_W  = 5;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Request opcodes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;    // latch the incoming request
        logic exec;       // run push, or start the head read of a pop
        logic pop_apply;  // retire the head entry
        logic scan;       // one step of the extreme rescan
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_pop;
        logic err;          // pop on empty or push on full
        logic need_rescan;  // popped value was an extreme and entries remain
        logic scan_done;
    } t_dp_stat;

endpackage

// ===== rtl/core/fwrmms_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module fwrmms_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 o_valid,
    output fwrmms_pkg::t_dp_cmd  o_cmd,
    input  fwrmms_pkg::t_dp_stat i_stat
);
    import fwrmms_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_POP    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                if (i_stat.err || !i_stat.is_pop) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                o_cmd.pop_apply = 1'b1;
                n_state = i_stat.need_rescan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// ===== rtl/core/fwrmms_dp.sv =====
// Datapath: entry memory, queue pointers, running statistics and rescan logic.
module fwrmms_dp #(
    parameter int QUEUE_DEPTH = fwrmms_pkg::DEF_QUEUE_DEPTH,
    parameter int VALUE_WIDTH = fwrmms_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cmd,
    input  logic signed [fwrmms_pkg::DATA_W-1:0]        i_value,
    input  fwrmms_pkg::t_dp_cmd                         i_dp_cmd,
    output fwrmms_pkg::t_dp_stat                        o_dp_stat,
    output logic        [fwrmms_pkg::STATUS_W-1:0]      o_status,
    output logic signed [fwrmms_pkg::DATA_W-1:0]        o_popped_value,
    output logic        [fwrmms_pkg::TOTAL_W-1:0]       o_entry_total,
    output logic signed [fwrmms_pkg::DATA_W-1:0]        o_largest,
    output logic signed [fwrmms_pkg::DATA_W-1:0]        o_smallest,
    output logic signed [fwrmms_pkg::SUM_W-1:0]         o_total_sum
);
    import fwrmms_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic signed [VALUE_WIDTH-1:0] mem [QUEUE_DEPTH];

    logic                          r_cmd;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]                 r_head;
    logic [AW-1:0]                 r_tail;
    logic [CW-1:0]                 r_count;
    logic signed [VALUE_WIDTH-1:0] r_max;
    logic signed [VALUE_WIDTH-1:0] r_min;
    logic signed [SUM_W-1:0]       r_sum;
    logic [STATUS_W-1:0]           r_status;
    logic signed [VALUE_WIDTH-1:0] r_popped;
    logic [AW-1:0]                 r_scan_ptr;
    logic [CW-1:0]                 r_scan_left;
    logic                          r_scan_pend;
    logic                          r_scan_first;
    logic                          r_need_max;
    logic                          r_need_min;

    logic          empty;
    logic          full;
    logic          eq_max;
    logic          eq_min;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          scan_issue;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        return (ptr == LAST_IDX) ? '0 : ptr + AW'(1);
    endfunction

    assign empty      = (r_count == '0);
    assign full       = (r_count == FULL_CNT);
    assign eq_max     = (r_rd_data == r_max);
    assign eq_min     = (r_rd_data == r_min);
    assign scan_issue = i_dp_cmd.scan && (r_scan_left != '0);
    assign wr_en      = i_dp_cmd.exec && (r_cmd == OP_PUSH) && !full;
    assign rd_en      = i_dp_cmd.exec || scan_issue;
    assign rd_addr    = i_dp_cmd.exec ? r_head : r_scan_ptr;

    assign o_dp_stat.is_pop      = (r_cmd == OP_POP);
    assign o_dp_stat.err         = (r_cmd == OP_POP) ? empty : full;
    assign o_dp_stat.need_rescan = (r_count != CW'(1)) && (eq_max || eq_min);
    assign o_dp_stat.scan_done   = (r_scan_left == '0) && !r_scan_pend;

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Request latch and result payload.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd    <= i_cmd;
            r_value  <= i_value[VALUE_WIDTH-1:0];
            r_popped <= '0;
            r_status <= ST_OK;
        end
        if (i_dp_cmd.exec) begin
            if (r_cmd == OP_POP) begin
                r_status <= empty ? ST_EMPTY : ST_OK;
            end else begin
                r_status <= full ? ST_FULL : ST_OK;
            end
        end
        if (i_dp_cmd.pop_apply) begin
            r_popped <= r_rd_data;
        end
    end

    // Queue pointers and running statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_max        <= '0;
            r_min        <= '0;
            r_sum        <= '0;
            r_scan_ptr   <= '0;
            r_scan_left  <= '0;
            r_scan_pend  <= 1'b0;
            r_scan_first <= 1'b0;
            r_need_max   <= 1'b0;
            r_need_min   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_tail  <= ptr_inc(r_tail);
                r_count <= r_count + CW'(1);
                if (empty) begin
                    r_max <= r_value;
                    r_min <= r_value;
                    r_sum <= SUM_W'(r_value);
                end else begin
                    if (r_value > r_max) begin
                        r_max <= r_value;
                    end
                    if (r_value < r_min) begin
                        r_min <= r_value;
                    end
                    r_sum <= r_sum + SUM_W'(r_value);
                end
            end
            if (i_dp_cmd.pop_apply) begin
                r_head       <= ptr_inc(r_head);
                r_count      <= r_count - CW'(1);
                r_scan_ptr   <= ptr_inc(r_head);
                r_scan_left  <= r_count - CW'(1);
                r_scan_pend  <= 1'b0;
                r_scan_first <= 1'b1;
                r_need_max   <= eq_max;
                r_need_min   <= eq_min;
                if (r_count == CW'(1)) begin
                    r_max <= '0;
                    r_min <= '0;
                    r_sum <= '0;
                end else begin
                    r_sum <= r_sum - SUM_W'(r_rd_data);
                end
            end
            if (i_dp_cmd.scan) begin
                // Issue one read a cycle, fold the previous read's data.
                if (scan_issue) begin
                    r_scan_ptr  <= ptr_inc(r_scan_ptr);
                    r_scan_left <= r_scan_left - CW'(1);
                end
                r_scan_pend <= scan_issue;
                if (r_scan_pend) begin
                    r_scan_first <= 1'b0;
                    if (r_need_max && (r_scan_first || (r_rd_data > r_max))) begin
                        r_max <= r_rd_data;
                    end
                    if (r_need_min && (r_scan_first || (r_rd_data < r_min))) begin
                        r_min <= r_rd_data;
                    end
                end
            end
        end
    end

    assign o_status       = r_status;
    assign o_popped_value = DATA_W'(r_popped);
    assign o_entry_total  = TOTAL_W'(r_count);
    assign o_largest      = DATA_W'(r_max);
    assign o_smallest     = DATA_W'(r_min);
    assign o_total_sum    = r_sum;

endmodule

// ===== rtl/core/fifo_with_running_min_max_sum_core.sv =====
// Top level: FIFO of signed values with running count, max, min and sum.
//
//   Port group        Dir  Handshake        Contents
//   request           in   start / busy     i_cmd, i_value
//   result            out  o_valid strobe   o_status, o_popped_value, o_entry_total,
//                                           o_largest, o_smallest, o_total_sum
//
// A push or an error passes through the decode and done states, and a pop that
// removes neither extreme passes through decode, pop and done. A pop that
// removes the maximum or the minimum also passes through a scan state that
// rescans the remaining entries through the single memory read port, one
// entry a cycle. One request is in flight at a time; busy stays high until the
// strobe cycle has passed, so the next request is accepted in the idle state
// that follows it at the earliest. Synchronous reset empties the queue and
// clears the statistics. Results cannot be stalled.
module fifo_with_running_min_max_sum_core #(
    parameter int QUEUE_DEPTH = fwrmms_pkg::DEF_QUEUE_DEPTH,
    parameter int VALUE_WIDTH = fwrmms_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cmd,
    input  logic signed [fwrmms_pkg::DATA_W-1:0]   i_value,
    output logic                                   o_valid,
    output logic        [fwrmms_pkg::STATUS_W-1:0] o_status,
    output logic signed [fwrmms_pkg::DATA_W-1:0]   o_popped_value,
    output logic        [fwrmms_pkg::TOTAL_W-1:0]  o_entry_total,
    output logic signed [fwrmms_pkg::DATA_W-1:0]   o_largest,
    output logic signed [fwrmms_pkg::DATA_W-1:0]   o_smallest,
    output logic signed [fwrmms_pkg::SUM_W-1:0]    o_total_sum
);
    import fwrmms_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fwrmms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    fwrmms_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_dp_cmd       (dp_cmd),
        .o_dp_stat      (dp_stat),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_total  (o_entry_total),
        .o_largest      (o_largest),
        .o_smallest     (o_smallest),
        .o_total_sum    (o_total_sum)
    );

endmodule
